// ===== rtl/atim_pkg.sv =====
`timescale 1ns / 1ps
// atim_pkg: types and constants shared by the alarm table timer
// used by atim_cell, atim_slot_unit and alarm_table_timer_top
package atim_pkg;

   localparam int EVENT_W = 8;
   localparam int AUX_W   = 32;
   localparam int DELAY_W = 31;
   localparam int TICK_W  = 32;
   localparam int WORD_W  = 32;
   localparam int OP_W    = 2;

   localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OP_W-1:0] OP_ARM     = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   // one alarm slot as it travels round the ring
   typedef struct packed {
      logic               active;
      logic               periodic;
      logic [DELAY_W-1:0] delay;
      logic [TICK_W-1:0]  expiry;
      logic [EVENT_W-1:0] event_id;
      logic [AUX_W-1:0]   aux;
   } slot_type;

   // status from the head unit for the slot under service
   typedef struct packed {
      logic hit;    // slot expired on this tick
      logic claim;  // slot taken by arm, cancel or restart
   } step_flags_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/atim_cell.sv =====
`timescale 1ns / 1ps
// atim_cell: one alarm slot of the rotating ring
// depends on atim_pkg for slot_type
module atim_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  atim_pkg::slot_type slot_in,
   output atim_pkg::slot_type slot_out
);
   import atim_pkg::*;

   logic     active_ff;
   slot_type data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (shift_en) begin
         active_ff <= slot_in.active;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= slot_in;
      end
   end

   always_comb begin
      slot_out        = data_ff;
      slot_out.active = active_ff;
   end

endmodule

// ===== rtl/atim_slot_unit.sv =====
`timescale 1ns / 1ps
// atim_slot_unit: serves the slot at the head of the ring for the current operation
// depends on atim_pkg for slot and flag types and opcodes
module atim_slot_unit (
   input  logic [atim_pkg::OP_W-1:0]    op,
   input  logic [atim_pkg::EVENT_W-1:0] event_id,
   input  logic [atim_pkg::WORD_W-1:0]  delay_word,
   input  logic [atim_pkg::AUX_W-1:0]   aux_data,
   input  logic [atim_pkg::TICK_W-1:0]  tick_count,
   input  logic                         done,
   input  atim_pkg::slot_type           slot_in,
   output atim_pkg::slot_type           slot_out,
   output atim_pkg::step_flags_type     flags
);
   import atim_pkg::*;

   logic [DELAY_W-1:0] delay_sel;
   logic [TICK_W-1:0]  reload;
   logic               match;
   logic               expired;

   // one adder shared by arm, restart and periodic reload
   assign delay_sel = (op == OP_ARM) ? delay_word[DELAY_W-1:0] : slot_in.delay;
   assign reload    = tick_count + {1'b0, delay_sel};
   assign match     = slot_in.active && (slot_in.event_id == event_id)
                      && (slot_in.aux == aux_data);
   assign expired   = slot_in.active && (slot_in.expiry <= tick_count);

   always_comb begin
      slot_out    = slot_in;
      flags.hit   = 1'b0;
      flags.claim = 1'b0;
      case (op)
         OP_TICK: begin
            if (expired) begin
               flags.hit = 1'b1;
               if (slot_in.periodic) begin
                  slot_out.expiry = reload;
               end else begin
                  slot_out.active = 1'b0;
               end
            end
         end
         OP_ARM: begin
            if (delay_word == '0) begin
               if (!done && match) begin
                  slot_out.active = 1'b0;
                  flags.claim     = 1'b1;
               end
            end else if (!done && !slot_in.active) begin
               slot_out.active   = 1'b1;
               slot_out.periodic = delay_word[WORD_W-1];
               slot_out.delay    = delay_word[DELAY_W-1:0];
               slot_out.expiry   = reload;
               slot_out.event_id = event_id;
               slot_out.aux      = aux_data;
               flags.claim       = 1'b1;
            end
         end
         OP_RESTART: begin
            if (!done && match) begin
               slot_out.expiry = reload;
               flags.claim     = 1'b1;
            end
         end
         default: begin
            slot_out = slot_in;
         end
      endcase
   end

endmodule

// ===== rtl/alarm_table_timer_top.sv =====
`timescale 1ns / 1ps
// alarm_table_timer_top: alarm slot ring, head unit, sequencer and result register
// depends on atim_pkg, atim_cell and atim_slot_unit
//
// Usage:
//   req_* carries operations: tick, arm or cancel, restart. One transfer is taken
//   when req_tready is high; the block then turns the slot ring once, one slot
//   per cycle through the head unit unless a stalled result channel holds it.
//   An item passes the idle state that takes the transfer, the ring scan and a
//   finishing state.
//   rsp_* returns results: expired alarms of a tick in slot order, or the
//   overflow event when arming finds the table full; rsp_tlast marks the final
//   result of an item. An item that causes no result gives no transfer.
//   A result does not appear when its slot is served, since
//   each expired alarm waits in a pending register until its successor (or the
//   end of the scan) decides its tlast.
//   When rsp_tready is low the ring stops at an expired slot that finds the
//   pending register full, and the pending result is held; nothing is dropped.
//   csr_wr_en writes the overflow event id; write it only while idle.
//   Synchronous reset clears all slots to inactive, the tick counter to zero and
//   the overflow id to zero. No clearing pass is needed.
module alarm_table_timer_top #(
   parameter int NUM_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // opcode[1:0], event_id[9:2], delay_word[41:10],
                                    // aux_data[73:42], zero[79:74]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // out_event_id[7:0], out_aux_data[39:8]
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data  // overflow_event_id
);
   import atim_pkg::*;

   localparam int CNT_W = $clog2(NUM_SLOTS + 1);

   logic [OP_W-1:0]    req_opcode;
   logic [EVENT_W-1:0] req_event_id;
   logic [WORD_W-1:0]  req_delay_word;
   logic [AUX_W-1:0]   req_aux_data;

   assign req_opcode     = req_tdata[1:0];
   assign req_event_id   = req_tdata[9:2];
   assign req_delay_word = req_tdata[41:10];
   assign req_aux_data   = req_tdata[73:42];

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic               done_ff, done_in;
   logic [OP_W-1:0]    op_ff;
   logic [EVENT_W-1:0] event_ff;
   logic [WORD_W-1:0]  word_ff;
   logic [AUX_W-1:0]   aux_ff;
   logic [TICK_W-1:0]  tick_count_ff;
   logic [EVENT_W-1:0] ovf_id_ff;

   logic               pend_valid_ff, pend_valid_in;
   logic [EVENT_W-1:0] pend_event_ff;
   logic [AUX_W-1:0]   pend_aux_ff;
   logic               pend_capture;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [EVENT_W-1:0] rsp_event_ff;
   logic [AUX_W-1:0]   rsp_aux_ff;
   logic               rsp_last_ff;

   logic               out_load;
   logic [EVENT_W-1:0] out_event;
   logic [AUX_W-1:0]   out_aux;
   logic               out_last;
   logic               out_busy;
   logic               shift_en;
   logic               req_accept;
   logic               overflow;

   slot_type           ring [NUM_SLOTS];
   slot_type           head_out;
   step_flags_type     flags;

   // slot ring: cell i takes from cell i+1, the last cell from the head unit
   for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
      slot_type cell_in;
      if (i == NUM_SLOTS - 1) begin : g_tail
         assign cell_in = head_out;
      end else begin : g_mid
         assign cell_in = ring[i+1];
      end
      atim_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (shift_en),
         .slot_in  (cell_in),
         .slot_out (ring[i])
      );
   end

   atim_slot_unit u_head (
      .op         (op_ff),
      .event_id   (event_ff),
      .delay_word (word_ff),
      .aux_data   (aux_ff),
      .tick_count (tick_count_ff),
      .done       (done_ff),
      .slot_in    (ring[0]),
      .slot_out   (head_out),
      .flags      (flags)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_busy   = rsp_valid_ff && !rsp_tready;
   assign overflow   = (op_ff == OP_ARM) && (word_ff != '0) && !done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         remain_ff     <= '0;
         done_ff       <= 1'b0;
         tick_count_ff <= '0;
         ovf_id_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         remain_ff     <= remain_in;
         done_ff       <= done_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_wr_en) begin
            ovf_id_ff <= csr_wr_data;
         end
         if (req_accept && (req_opcode == OP_TICK)) begin
            tick_count_ff <= tick_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         op_ff    <= req_opcode;
         event_ff <= req_event_id;
         word_ff  <= req_delay_word;
         aux_ff   <= req_aux_data;
      end
      if (pend_capture) begin
         pend_event_ff <= ring[0].event_id;
         pend_aux_ff   <= ring[0].aux;
      end
      if (out_load) begin
         rsp_event_ff <= out_event;
         rsp_aux_ff   <= out_aux;
         rsp_last_ff  <= out_last;
      end
   end

   always_comb begin
      state_in      = state_ff;
      remain_in     = remain_ff;
      done_in       = done_ff;
      shift_en      = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_capture  = 1'b0;
      out_load      = 1'b0;
      out_event     = pend_event_ff;
      out_aux       = pend_aux_ff;
      out_last      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in  = ST_SCAN;
               remain_in = CNT_W'(NUM_SLOTS);
               done_in   = 1'b0;
            end
         end
         ST_SCAN: begin
            // hold the ring while an earlier result cannot leave
            if (!(flags.hit && pend_valid_ff && out_busy)) begin
               shift_en  = 1'b1;
               remain_in = remain_ff - 1'b1;
               if (flags.claim) begin
                  done_in = 1'b1;
               end
               if (flags.hit) begin
                  out_load      = pend_valid_ff;
                  pend_capture  = 1'b1;
                  pend_valid_in = 1'b1;
               end
               if (remain_ff == CNT_W'(1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff || overflow) begin
               if (!out_busy) begin
                  out_load      = 1'b1;
                  out_last      = 1'b1;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
                  if (!pend_valid_ff) begin
                     out_event = ovf_id_ff;
                     out_aux   = '0;
                  end
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_aux_ff, rsp_event_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_load |-> !out_busy)
      else $error("result register loaded while a transfer is pending");

   a_tick_step : assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_opcode == OP_TICK)
      |=> tick_count_ff == $past(tick_count_ff) + 1'b1)
      else $error("tick counter did not advance on a tick");

   a_scan_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (remain_ff != '0))
      else $error("scan running with no slots left");

   a_idle_drained : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pending result left behind after an item");

endmodule
